// ===== rtl/grmc_pkg.sv =====
package grmc_pkg;

  localparam int MapDimDefault    = 32;
  localparam int TrigBitsDefault  = 10;

  localparam int ScreenW  = 12;
  localparam int AngleW   = 32;
  localparam int StepW    = 10;
  localparam int PosW     = 16;
  localparam int ColW     = 12;
  localparam int DistW    = 17;
  localparam int HeightW  = 16;
  localparam int StartW   = 16;
  localparam int EndW     = 17;
  localparam int TrigW    = 16;   // signed Q1.14 plus sign
  localparam int DeltaW   = 26;   // signed trig * step
  localparam int StepCntW = 18;   // up to 131072 steps

  localparam int unsigned MaxSteps = 131072;

  localparam logic [ScreenW-1:0] ScreenHeightRst = 12'd600;
  localparam logic [AngleW-1:0]  FovHalfRst      = 32'd357913941;
  localparam logic [AngleW-1:0]  AnglePerColRst  = 32'd894785;
  localparam logic [StepW-1:0]   MarchStepRst    = 10'd102;

  localparam logic [AngleW-1:0]  QuarterTurn     = 32'h4000_0000;

  typedef enum logic [1:0] {
    REG_SCREEN_HEIGHT = 2'd0,
    REG_FOV_HALF      = 2'd1,
    REG_ANGLE_PER_COL = 2'd2,
    REG_MARCH_STEP    = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_WRITE_LINE = 1'b0,
    OP_CAST_RAY   = 1'b1
  } opcode_t;

  // request carried from the front end to the marcher
  typedef struct packed {
    logic [PosW-1:0]   pos_x;
    logic [PosW-1:0]   pos_y;
    logic [AngleW-1:0] ray;
    logic [ColW-1:0]   column;
  } ray_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_SETUP,
    ST_STEP,
    ST_TEST,
    ST_DIST,
    ST_DIV,
    ST_OUT
  } mst_t;

endpackage

// ===== rtl/grid_ray_march_column.sv =====
// Column ray caster over a MAP_DIM x MAP_DIM wall bit map. A write-line request
// updates one map line, but is held off (full high) until every earlier cast
// has left the marcher. A cast request leaves the queue; cosine, then sine, are
// evaluated in states MUL1 to MUL4, later terms on one shared multiplier; a setup
// state follows, then per march step a position-add and a map-test state, then a
// distance state, a bit-serial divide and an output state that waits while an
// unpopped result is held. A two-entry request queue lets new cast requests be
// taken while a ray is marching; results wait in an output register until popped.
module grid_ray_march_column import grmc_pkg::*; #(
  parameter int MAP_DIM         = MapDimDefault,
  parameter int TRIG_TABLE_BITS = TrigBitsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_opcode,
  input  logic [4:0]         in_line_index,
  input  logic [31:0]        in_line_bits,
  input  logic [PosW-1:0]    in_pos_x,
  input  logic [PosW-1:0]    in_pos_y,
  input  logic [AngleW-1:0]  in_view_angle,
  input  logic [ColW-1:0]    in_column,
  output logic               empty,
  input  logic               pop,
  output logic [ColW-1:0]    out_column_out,
  output logic [DistW-1:0]   out_distance,
  output logic [HeightW-1:0] out_wall_height,
  output logic signed [StartW-1:0] out_draw_start,
  output logic signed [EndW-1:0]   out_draw_end,
  output logic               out_bright_shade,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IDX_W = (MAP_DIM > 1) ? $clog2(MAP_DIM) : 1;

  logic [ScreenW-1:0] scr_r;
  logic [AngleW-1:0]  fov_r, apc_r;
  logic [StepW-1:0]   stp_r;
  logic               in_ready, wr_en, q_push, q_full, q_pop, q_empty, bk_busy;
  logic [IDX_W-1:0]   wr_idx;
  logic [MAP_DIM-1:0] wr_bits;
  ray_req_t           q_in, q_out;
  reg_idx_t           ridx;

  // configuration registers
  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[3:2]);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_r <= ScreenHeightRst;
      fov_r <= FovHalfRst;
      apc_r <= AnglePerColRst;
      stp_r <= MarchStepRst;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (ridx)
        REG_SCREEN_HEIGHT: scr_r <= pwdata[ScreenW-1:0];
        REG_FOV_HALF:      fov_r <= pwdata;
        REG_ANGLE_PER_COL: apc_r <= pwdata;
        REG_MARCH_STEP:    stp_r <= pwdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_SCREEN_HEIGHT: prdata = {20'd0, scr_r};
      REG_FOV_HALF:      prdata = fov_r;
      REG_ANGLE_PER_COL: prdata = apc_r;
      REG_MARCH_STEP:    prdata = {22'd0, stp_r};
      default:           prdata = '0;
    endcase
  end

  assign full = !in_ready;

  grmc_front #(.MAP_DIM(MAP_DIM), .IDX_W(IDX_W)) u_front (
    .in_valid(push), .in_ready,
    .opcode(in_opcode), .line_index(in_line_index), .line_bits(in_line_bits),
    .pos_x(in_pos_x), .pos_y(in_pos_y), .view_angle(in_view_angle),
    .column(in_column), .fov_half(fov_r), .angle_per_column(apc_r),
    .busy(bk_busy),
    .wr_en, .wr_idx, .wr_bits, .q_push, .q_full, .q_data(q_in));

  grmc_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_data(q_out));

  grmc_march #(.MAP_DIM(MAP_DIM), .TRIG_TABLE_BITS(TRIG_TABLE_BITS),
               .IDX_W(IDX_W)) u_march (
    .clk, .rst_n, .wr_en, .wr_idx, .wr_bits,
    .q_empty, .q_pop, .q_data(q_out), .busy(bk_busy),
    .scr_rows(scr_r), .march_step(stp_r),
    .out_empty(empty), .out_pop(pop),
    .column_out(out_column_out), .distance(out_distance),
    .wall_height(out_wall_height), .draw_start(out_draw_start),
    .draw_end(out_draw_end), .bright_shade(out_bright_shade));

endmodule

// ===== rtl/grmc_front.sv =====
// Front end: takes requests, writes map lines, forms the ray angle for casts.
module grmc_front import grmc_pkg::*; #(
  parameter int MAP_DIM = MapDimDefault,
  parameter int IDX_W   = $clog2(MapDimDefault)
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              opcode,
  input  logic [4:0]        line_index,
  input  logic [31:0]       line_bits,
  input  logic [PosW-1:0]   pos_x,
  input  logic [PosW-1:0]   pos_y,
  input  logic [AngleW-1:0] view_angle,
  input  logic [ColW-1:0]   column,
  input  logic [AngleW-1:0] fov_half,
  input  logic [AngleW-1:0] angle_per_column,
  input  logic              busy,
  output logic              wr_en,
  output logic [IDX_W-1:0]  wr_idx,
  output logic [MAP_DIM-1:0] wr_bits,
  output logic              q_push,
  input  logic              q_full,
  output ray_req_t          q_data
);

  logic [AngleW-1:0] col_ang;
  logic              is_cast;

  assign is_cast  = (opcode_t'(opcode) == OP_CAST_RAY);
  // a line write waits until every earlier cast has finished reading the map
  assign in_ready = is_cast ? !q_full : !busy;

  // map line write, out of range lines dropped
  assign wr_en   = in_valid && in_ready && !is_cast && (32'(line_index) < 32'(MAP_DIM));
  assign wr_idx  = IDX_W'(line_index);
  assign wr_bits = MAP_DIM'(line_bits);

  // ray angle, modulo a full turn
  assign col_ang = AngleW'(angle_per_column * {20'd0, column});
  assign q_push  = in_valid && in_ready && is_cast;
  assign q_data  = '{pos_x: pos_x, pos_y: pos_y,
                     ray: view_angle - fov_half + col_ang, column: column};

endmodule

// ===== rtl/grmc_queue.sv =====
// Two-entry request queue between front and marcher.
module grmc_queue import grmc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ray_req_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output ray_req_t pop_data
);

  ray_req_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count overflow");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |=> cnt_r == 2'd2) else $error("full queue lost entry");
  a_empty_push: assert property (@(posedge clk) disable iff (!rst_n)
    empty && push |=> !empty) else $error("push lost");

endmodule

// ===== rtl/grmc_sin.sv =====
// Angle fold for the polynomial sine: quarter turn and mirrored Q16 fraction.
module grmc_sin import grmc_pkg::*; #(
  parameter int TRIG_TABLE_BITS = TrigBitsDefault
) (
  input  logic [AngleW-1:0] angle,
  output logic [16:0]       x,       // Q16 fraction, mirrored
  output logic              neg
);

  localparam int QW = TRIG_TABLE_BITS - 2;

  logic [TRIG_TABLE_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [16:0]                xr;

  assign idx  = angle[AngleW-1 -: TRIG_TABLE_BITS];
  assign quad = idx[TRIG_TABLE_BITS-1 -: 2];
  assign xr   = 17'({idx[QW-1:0], 16'd0} >> QW);
  assign x    = quad[0] ? 17'(17'h10000 - xr) : xr;
  assign neg  = quad[1];

endmodule

// ===== rtl/grmc_march.sv =====
// Back end: trig evaluation, fixed-step march over the map, serial divide.
module grmc_march import grmc_pkg::*; #(
  parameter int MAP_DIM         = MapDimDefault,
  parameter int TRIG_TABLE_BITS = TrigBitsDefault,
  parameter int IDX_W           = $clog2(MapDimDefault)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_idx,
  input  logic [MAP_DIM-1:0] wr_bits,
  input  logic               q_empty,
  output logic               q_pop,
  input  ray_req_t           q_data,
  output logic               busy,
  input  logic [ScreenW-1:0] scr_rows,
  input  logic [StepW-1:0]   march_step,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [ColW-1:0]    column_out,
  output logic [DistW-1:0]   distance,
  output logic [HeightW-1:0] wall_height,
  output logic signed [StartW-1:0] draw_start,
  output logic signed [EndW-1:0]   draw_end,
  output logic               bright_shade
);

  localparam int PW  = 40;            // Q.24 position, signed, spare bits
  localparam int CW  = 6 + 24 + 2;    // cell bits kept in range check
  localparam int QW  = 27;            // dividend register width (12+10 bit dividend)

  // map with valid bits
  logic [MAP_DIM-1:0] map_r [MAP_DIM];
  logic [MAP_DIM-1:0] vld_r;

  mst_t st_r, st_nxt;
  ray_req_t          req_r;
  logic [StepW-1:0]  stp_r;
  logic              pass_r;          // 0 sine of cos angle, 1 sine
  logic [16:0]       x_r;
  logic              neg_r;
  logic [33:0]       x2_r, t_r;
  logic signed [TrigW-1:0] cos_r, sin_r;
  logic signed [PW-1:0] px_r, py_r;
  logic signed [DeltaW-1:0] dx_r, dy_r;
  logic [StepCntW-1:0] cnt_r;
  logic [DistW-1:0]  dist_r;
  logic [QW-1:0]     rem_r, quo_r;
  logic [4:0]        dcnt_r;
  logic              blk;

  logic [AngleW-1:0] sang;
  logic [16:0]       sx;
  logic              sneg;
  logic [33:0]       prod_b;
  logic [16:0]       coef;
  logic [33:0]       tq;
  logic signed [TrigW-1:0] trig_res;
  logic [27:0]       dsub;
  logic [DistW+StepW:0] dfull;
  logic [HeightW-1:0] hgt;
  logic signed [StartW:0] st_v;
  logic [TrigW-1:0]  ac, as_v;

  // out register
  logic              ov_r;

  assign sang = pass_r ? req_r.ray : req_r.ray + QuarterTurn;
  grmc_sin #(.TRIG_TABLE_BITS(TRIG_TABLE_BITS)) u_sin (
    .angle(sang), .x(sx), .neg(sneg));

  // one shared multiplier stage chain: coefficient minus t, times x2 (or x)
  always_comb begin
    coef = 17'd0;
    case (st_r)
      ST_MUL2: coef = 17'd5223;
      ST_MUL3: coef = 17'd42334;
      ST_MUL4: coef = 17'd102944;
      default: coef = 17'd0;
    endcase
  end
  assign prod_b = 34'(coef - 17'(t_r)) * ((st_r == ST_MUL4) ? 34'(x_r) : x2_r);
  assign tq     = (prod_b >> 16) >> 2;
  assign trig_res = (tq > 34'd16384) ? TrigW'(16384) : TrigW'(tq);

  // map lookup on the current position
  always_comb begin
    logic [CW-1:0] cx, cy;
    cx = CW'(px_r >>> 24);
    cy = CW'(py_r >>> 24);
    blk = 1'b1;
    if (!px_r[PW-1] && !py_r[PW-1] && cx < CW'(MAP_DIM) && cy < CW'(MAP_DIM))
      blk = vld_r[cx[IDX_W-1:0]] && map_r[cx[IDX_W-1:0]][cy[IDX_W-1:0]];
  end

  assign dsub  = {rem_r[QW-2:0], quo_r[QW-1]} - 28'(dist_r);
  assign dfull = (DistW+StepW+1)'(cnt_r) * (DistW+StepW+1)'(stp_r);
  assign hgt   = (quo_r > QW'(65535)) ? 16'hFFFF : HeightW'(quo_r);
  assign st_v  = (StartW+1)'(scr_rows >> 1) - (StartW+1)'(hgt >> 1);
  assign ac    = cos_r < 0 ? TrigW'(-cos_r) : TrigW'(cos_r);
  assign as_v  = sin_r < 0 ? TrigW'(-sin_r) : TrigW'(sin_r);

  // a cast is waiting or on its way through the marcher
  assign busy = !q_empty || (st_r != ST_IDLE);

  always_comb begin
    st_nxt = st_r;
    q_pop  = 1'b0;
    case (st_r)
      ST_IDLE:  if (!q_empty) begin q_pop = 1'b1; st_nxt = ST_MUL1; end
      ST_MUL1:  st_nxt = ST_MUL2;
      ST_MUL2:  st_nxt = ST_MUL3;
      ST_MUL3:  st_nxt = ST_MUL4;
      ST_MUL4:  st_nxt = pass_r ? ST_SETUP : ST_MUL1;
      ST_SETUP: st_nxt = ST_STEP;
      ST_STEP:  st_nxt = ST_TEST;
      ST_TEST:  st_nxt = (blk || cnt_r == StepCntW'(MaxSteps)) ? ST_DIST : ST_STEP;
      ST_DIST:  st_nxt = ST_DIV;
      ST_DIV:   if (dcnt_r == 5'd0) st_nxt = ST_OUT;
      ST_OUT:   if (!ov_r || out_pop) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      vld_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (wr_en) vld_r[wr_idx] <= 1'b1;
      if (st_r == ST_OUT && (!ov_r || out_pop)) ov_r <= 1'b1;
      else if (out_pop) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) map_r[wr_idx] <= wr_bits;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        req_r  <= q_data;
        stp_r  <= (march_step == '0) ? StepW'(1) : march_step;
        pass_r <= 1'b0;
      end
      ST_MUL1: begin
        x_r   <= sx;
        neg_r <= sneg;
        x2_r  <= 34'({sx, 16'd0} == 33'd0 ? 34'd0 : (34'(sx) * 34'(sx)) >> 16);
        t_r   <= ((34'd307 * ((34'(sx) * 34'(sx)) >> 16)) >> 16);
      end
      ST_MUL2: t_r <= prod_b >> 16;
      ST_MUL3: t_r <= prod_b >> 16;
      ST_MUL4: begin
        // last term times x, scaled to Q1.14 and clamped
        if (pass_r) sin_r <= neg_r ? -trig_res : trig_res;
        else        cos_r <= neg_r ? -trig_res : trig_res;
        pass_r <= 1'b1;
      end
      ST_SETUP: begin
        px_r  <= PW'(signed'({1'b0, req_r.pos_x})) <<< 14;
        py_r  <= PW'(signed'({1'b0, req_r.pos_y})) <<< 14;
        dx_r  <= DeltaW'(cos_r * signed'({1'b0, stp_r}));
        dy_r  <= DeltaW'(sin_r * signed'({1'b0, stp_r}));
        cnt_r <= '0;
      end
      ST_STEP: begin
        px_r  <= px_r + PW'(dx_r);
        py_r  <= py_r + PW'(dy_r);
        cnt_r <= cnt_r + 1'b1;
      end
      ST_DIST: begin
        dist_r <= (dfull > (DistW+StepW+1)'(131071)) ? 17'h1FFFF : DistW'(dfull);
        rem_r  <= '0;
        quo_r  <= QW'({scr_rows, 10'd0});
        dcnt_r <= 5'(QW - 1);
      end
      ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (!dsub[27] || rem_r[QW-1]) begin
          rem_r <= QW'({rem_r[QW-2:0], quo_r[QW-1]} - QW'(dist_r));
          quo_r <= {quo_r[QW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[QW-2:0], quo_r[QW-1]};
          quo_r <= {quo_r[QW-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r - 1'b1;
      end
      ST_OUT: if (!ov_r || out_pop) begin
        column_out   <= req_r.column;
        distance     <= dist_r;
        wall_height  <= hgt;
        draw_start   <= StartW'(st_v);
        draw_end     <= EndW'(st_v) + EndW'(signed'({1'b0, hgt}));
        bright_shade <= (ac > as_v);
      end
      default: ;
    endcase
  end

  assign out_empty = !ov_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == ST_IDLE) else $error("pop outside idle");
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DIV && dcnt_r == 5'd0 |=> st_r == ST_OUT) else $error("divide overran");
  a_out_new: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(st_r) == ST_OUT) else $error("result out of sequence");

endmodule
